@@ design/pfrb_pkg.sv @@
package pfrb_pkg;

    // Fixed field widths of the stream port
    localparam int OP_W      = 4;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 4;
    localparam int STS_W     = 2;
    localparam int POS_W     = 12;
    localparam int STATE_W   = 3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_RING_FRAMES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THR   = 4'd1;

    // Register reset values and ring size floor
    localparam int RING_FRAMES_RST = 4096;
    localparam int START_THR_RST   = 2048;
    localparam int MIN_FRAMES      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 4'd0,
        OP_POP     = 4'd1,
        OP_ADV_HW  = 4'd2,
        OP_FWD_APP = 4'd3,
        OP_REW_APP = 4'd4,
        OP_PREPARE = 4'd5,
        OP_START   = 4'd6,
        OP_DROP    = 4'd7,
        OP_DRAIN   = 4'd8,
        OP_PAUSE   = 4'd9,
        OP_RESUME  = 4'd10,
        OP_STATUS  = 4'd11
    } t_op;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_NA    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        ST_SETUP    = 5'b00001,
        ST_PREPARED = 5'b00010,
        ST_RUNNING  = 5'b00100,
        ST_DRAINING = 5'b01000,
        ST_PAUSED   = 5'b10000
    } t_run_state;

    // Status of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_sts;

    // External stream state code
    function automatic logic [STATE_W-1:0] state_code(t_run_state s);
        logic [STATE_W-1:0] c;
        unique case (s)
            ST_SETUP:    c = 3'd0;
            ST_PREPARED: c = 3'd1;
            ST_RUNNING:  c = 3'd2;
            ST_DRAINING: c = 3'd3;
            ST_PAUSED:   c = 3'd4;
            default:     c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

@@ design/pfrb_ptr_mod.sv @@
// Bit-serial restoring remainder: o_rem = i_dividend mod i_divisor.
// One dividend bit per cycle; o_sts.done is raised once all DW dividend bits are in.
module pfrb_ptr_mod #(
    parameter int DW = 14,
    parameter int SW = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [SW-1:0]       i_divisor,
    output logic [SW-1:0]       o_rem,
    output pfrb_pkg::t_mod_sts  o_sts
);
    import pfrb_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_div;
    logic [SW-1:0] r_den;
    logic [SW-1:0] r_rem;

    logic [SW:0]   trial;
    logic [SW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_div[DW-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = SW'(trial - {1'b0, r_den});
        end else begin
            n_rem = SW'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rem      = r_rem;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

@@ design/pcm_frame_ring_buffer.sv @@
// PCM frame ring buffer. Frames are pushed at the application pointer and
// popped at the hardware pointer; both wrap at the configured ring size
// (ring_frames clamped to 2..RING_DEPTH), and one slot always stays empty.
// Every operation returns one result with the status, fill level, free
// space, stream state and both pointers after the operation; a pop also
// returns the frame. Throughput is one operation per clock while results
// are taken: an accepted item sits in an input register, is executed in
// one pass against the pointer/state registers and the frame RAM, and its
// result is shown from an output register the next cycle, so an item is
// accepted while a result still waits to be taken. Exceptions: an
// advance-hw or forward-app whose pointer + count reaches twice the ring
// size is reduced by a bit-serial remainder unit, and no new item is taken
// until it is done. A write to ring_frames re-wraps both stored pointers
// through the same units, and no item is taken until that is done. Reading
// a slot never written since reset returns an undefined frame.
module pcm_frame_ring_buffer #(
    parameter int RING_DEPTH = 4096,
    parameter int FRAME_W    = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfrb_pkg::CFG_W-1:0]     i_cfg_data,
    // operation channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pfrb_pkg::OP_W-1:0]      i_operation,
    input  logic [pfrb_pkg::DATA_W-1:0]    i_frame_data,
    input  logic [pfrb_pkg::CNT_W-1:0]     i_frame_count,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pfrb_pkg::DATA_W-1:0]    o_read_data,
    output logic [pfrb_pkg::STS_W-1:0]     o_status,
    output logic [pfrb_pkg::POS_W-1:0]     o_fill_level,
    output logic [pfrb_pkg::POS_W-1:0]     o_free_space,
    output logic [pfrb_pkg::STATE_W-1:0]   o_stream_state,
    output logic [pfrb_pkg::POS_W-1:0]     o_app_position,
    output logic [pfrb_pkg::POS_W-1:0]     o_hw_position
);
    import pfrb_pkg::*;

    // Pointer and size widths
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int SZ_W   = $clog2(RING_DEPTH + 1);
    localparam int CW     = (SZ_W > CNT_W) ? SZ_W : CNT_W;
    localparam int SUM_W  = CW + 1;
    localparam int SZ_RST = (RING_FRAMES_RST > RING_DEPTH) ? RING_DEPTH : RING_FRAMES_RST;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [SZ_W-1:0]  r_size;       // effective ring size
    logic [CFG_W-1:0] r_thr;        // raw start threshold
    logic             cfg_wr;
    logic             cfg_size_wr;
    logic [CW-1:0]    cfg_ext;
    logic [SZ_W-1:0]  cfg_eff_size;
    logic [CW-1:0]    thr_eff;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_size_wr = cfg_wr && (i_cfg_index == CFG_RING_FRAMES);
    assign cfg_ext     = CW'(i_cfg_data);

    always_comb begin
        priority if (cfg_ext < CW'(MIN_FRAMES)) begin
            cfg_eff_size = SZ_W'(MIN_FRAMES);
        end else if (cfg_ext > CW'(RING_DEPTH)) begin
            cfg_eff_size = SZ_W'(RING_DEPTH);
        end else begin
            cfg_eff_size = SZ_W'(cfg_ext);
        end
    end

    // threshold above the size falls back to half the size
    assign thr_eff = (CW'(r_thr) > CW'(r_size)) ? CW'(r_size >> 1) : CW'(r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SZ_W'(SZ_RST);
            r_thr  <= CFG_W'(START_THR_RST);
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_RING_FRAMES) begin
                r_size <= cfg_eff_size;
            end
            if (i_cfg_index == CFG_START_THR) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                  r_in_valid;
    logic [OP_W-1:0]       r_in_op;
    logic [FRAME_W-1:0]    r_in_data;
    logic [CNT_W-1:0]      r_in_cnt;
    logic                  in_xfer;
    logic                  exec;
    logic                  out_free;

    logic                  r_norm;      // pointer re-wrap after size change
    logic                  r_long;      // item waits on a remainder unit

    assign out_free   = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_norm && (!r_in_valid || exec);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op   <= i_operation;
            r_in_data <= FRAME_W'(i_frame_data);
            r_in_cnt  <= i_frame_count;
        end
    end

    // ---------------------------------------------------------------
    // Pointer arithmetic
    // ---------------------------------------------------------------
    logic [PTR_W-1:0] r_app;
    logic [PTR_W-1:0] r_hw;
    t_run_state       r_state;

    logic [SZ_W-1:0]  fill_cur;
    logic [SZ_W-1:0]  free_cur;
    logic [SUM_W-1:0] size_x2;
    logic [SUM_W-1:0] app_sum;
    logic [SUM_W-1:0] hw_sum;
    logic [SUM_W-1:0] app_wrap;
    logic [SUM_W-1:0] hw_wrap;
    logic             app_long;
    logic             hw_long;
    logic             need_long;
    logic             long_busy;
    logic [PTR_W-1:0] app_inc;
    logic [PTR_W-1:0] hw_inc;

    assign fill_cur = (r_app >= r_hw) ? SZ_W'(r_app) - SZ_W'(r_hw)
                                      : SZ_W'(r_app) + r_size - SZ_W'(r_hw);
    assign free_cur = r_size - fill_cur - SZ_W'(1);

    assign size_x2  = {SUM_W'(r_size)} << 1;
    assign app_sum  = SUM_W'(r_app) + SUM_W'(r_in_cnt);
    assign hw_sum   = SUM_W'(r_hw) + SUM_W'(r_in_cnt);
    assign app_wrap = (app_sum >= SUM_W'(r_size)) ? app_sum - SUM_W'(r_size) : app_sum;
    assign hw_wrap  = (hw_sum >= SUM_W'(r_size)) ? hw_sum - SUM_W'(r_size) : hw_sum;

    // sums that wrap more than once go through the remainder units
    assign app_long  = (t_op'(r_in_op) == OP_FWD_APP) && (app_sum >= size_x2);
    assign hw_long   = (t_op'(r_in_op) == OP_ADV_HW) && (hw_sum >= size_x2);
    assign need_long = app_long || hw_long;

    assign app_inc = (SZ_W'(r_app) + SZ_W'(1) == r_size) ? '0 : r_app + PTR_W'(1);
    assign hw_inc  = (SZ_W'(r_hw) + SZ_W'(1) == r_size) ? '0 : r_hw + PTR_W'(1);

    // ---------------------------------------------------------------
    // Remainder units, one per pointer
    // ---------------------------------------------------------------
    t_mod_sts         sts_app;
    t_mod_sts         sts_hw;
    logic [SZ_W-1:0]  rem_app;
    logic [SZ_W-1:0]  rem_hw;
    logic             long_start;
    logic             start_app;
    logic             start_hw;
    logic [SUM_W-1:0] div_app;
    logic [SUM_W-1:0] div_hw;
    logic [SZ_W-1:0]  den;

    assign long_start = r_in_valid && need_long && !r_long && !r_norm;
    assign start_app  = cfg_size_wr || (long_start && app_long);
    assign start_hw   = cfg_size_wr || (long_start && hw_long);
    assign div_app    = cfg_size_wr ? SUM_W'(r_app) : app_sum;
    assign div_hw     = cfg_size_wr ? SUM_W'(r_hw) : hw_sum;
    assign den        = cfg_size_wr ? cfg_eff_size : r_size;
    assign long_busy  = sts_app.busy || sts_hw.busy;

    pfrb_ptr_mod #(
        .DW (SUM_W),
        .SW (SZ_W)
    ) u_mod_app (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_app),
        .i_dividend (div_app),
        .i_divisor  (den),
        .o_rem      (rem_app),
        .o_sts      (sts_app)
    );

    pfrb_ptr_mod #(
        .DW (SUM_W),
        .SW (SZ_W)
    ) u_mod_hw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_hw),
        .i_dividend (div_hw),
        .i_divisor  (den),
        .o_rem      (rem_hw),
        .o_sts      (sts_hw)
    );

    assign exec = r_in_valid && !r_norm && out_free
               && (!need_long || (r_long && !long_busy));

    // ---------------------------------------------------------------
    // Operation decode
    // ---------------------------------------------------------------
    logic [PTR_W-1:0] n_app;
    logic [PTR_W-1:0] n_hw;
    t_run_state       n_state;
    t_status          n_status;
    logic             push_ok;
    logic             pop_ok;
    logic [SZ_W-1:0]  fill_n;
    logic [SZ_W-1:0]  free_n;

    always_comb begin
        n_app    = r_app;
        n_hw     = r_hw;
        n_state  = r_state;
        n_status = STS_OK;
        push_ok  = 1'b0;
        pop_ok   = 1'b0;
        unique case (t_op'(r_in_op))
            OP_PUSH: begin
                if (r_state == ST_SETUP) begin
                    n_state = ST_PREPARED;
                end
                if (free_cur == '0) begin
                    n_status = STS_FULL;
                end else begin
                    push_ok = 1'b1;
                    n_app   = app_inc;
                    // fill after the push is fill_cur + 1
                    if (n_state == ST_PREPARED && CW'(fill_cur) + CW'(1) >= thr_eff) begin
                        n_state = ST_RUNNING;
                    end
                end
            end
            OP_POP: begin
                priority if (r_state == ST_SETUP) begin
                    n_status = STS_NA;
                end else if (fill_cur == '0) begin
                    n_status = STS_EMPTY;
                end else begin
                    pop_ok = 1'b1;
                    n_hw   = hw_inc;
                end
            end
            OP_ADV_HW: begin
                n_hw = hw_long ? PTR_W'(rem_hw) : PTR_W'(hw_wrap);
            end
            OP_FWD_APP: begin
                n_app = app_long ? PTR_W'(rem_app) : PTR_W'(app_wrap);
            end
            OP_REW_APP: begin
                // saturate at slot zero
                n_app = (CW'(r_app) >= CW'(r_in_cnt)) ? PTR_W'(CW'(r_app) - CW'(r_in_cnt))
                                                      : '0;
            end
            OP_PREPARE: begin
                n_state = ST_PREPARED;
                n_app   = '0;
                n_hw    = '0;
            end
            OP_START: begin
                if (r_state == ST_PREPARED) begin
                    n_state = ST_RUNNING;
                end
            end
            OP_DROP: begin
                n_state = ST_SETUP;
                n_app   = '0;
                n_hw    = '0;
            end
            OP_DRAIN: begin
                if (r_state == ST_RUNNING) begin
                    n_state = ST_DRAINING;
                end
            end
            OP_PAUSE: begin
                n_state = ST_PAUSED;
            end
            OP_RESUME: begin
                n_state = ST_RUNNING;
            end
            OP_STATUS: begin
            end
            default: begin
                n_status = STS_NA;
            end
        endcase
    end

    assign fill_n = (n_app >= n_hw) ? SZ_W'(n_app) - SZ_W'(n_hw)
                                    : SZ_W'(n_app) + r_size - SZ_W'(n_hw);
    assign free_n = r_size - fill_n - SZ_W'(1);

    // ---------------------------------------------------------------
    // Stream state and pointers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app   <= '0;
            r_hw    <= '0;
            r_state <= ST_SETUP;
            r_norm  <= 1'b0;
            r_long  <= 1'b0;
        end else begin
            // size change: re-wrap both pointers, restart on a second write
            if (cfg_size_wr) begin
                r_norm <= 1'b1;
            end else if (r_norm && sts_app.done) begin
                r_norm <= 1'b0;
                r_app  <= PTR_W'(rem_app);
                r_hw   <= PTR_W'(rem_hw);
            end
            if (long_start) begin
                r_long <= 1'b1;
            end
            if (exec) begin
                r_long  <= 1'b0;
                r_app   <= n_app;
                r_hw    <= n_hw;
                r_state <= n_state;
            end
        end
    end

    // ---------------------------------------------------------------
    // Frame RAM, registered read at the hw pointer
    // ---------------------------------------------------------------
    logic [FRAME_W-1:0] r_ring [RING_DEPTH];
    logic [FRAME_W-1:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (exec && push_ok) begin
            r_ring[r_app] <= r_in_data;
        end
        if (exec && pop_ok) begin
            r_rd_q <= r_ring[r_hw];
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                r_out_valid;
    logic                r_out_rd_sel;
    logic [STS_W-1:0]    r_out_status;
    logic [POS_W-1:0]    r_out_fill;
    logic [POS_W-1:0]    r_out_free;
    logic [STATE_W-1:0]  r_out_state;
    logic [POS_W-1:0]    r_out_app;
    logic [POS_W-1:0]    r_out_hw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_rd_sel <= pop_ok;
            r_out_status <= n_status;
            r_out_fill   <= POS_W'(fill_n);
            r_out_free   <= POS_W'(free_n);
            r_out_state  <= state_code(n_state);
            r_out_app    <= POS_W'(n_app);
            r_out_hw     <= POS_W'(n_hw);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_rd_sel ? DATA_W'(r_rd_q) : '0;
    assign o_status       = r_out_status;
    assign o_fill_level   = r_out_fill;
    assign o_free_space   = r_out_free;
    assign o_stream_state = r_out_state;
    assign o_app_position = r_out_app;
    assign o_hw_position  = r_out_hw;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // both re-wrap units run in lockstep
    a_norm_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_norm && sts_app.done) |-> sts_hw.done)
        else $error("pointer re-wrap units out of step");

    // stored pointers stay inside the ring once re-wrapped
    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_norm |-> ((SZ_W'(r_app) < r_size) && (SZ_W'(r_hw) < r_size)))
        else $error("pointer outside ring");

    // a long pointer move only waits for a held item
    a_long_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long |-> (r_in_valid && !r_norm))
        else $error("remainder wait without item");

endmodule
